[design/mhm_pkg.sv]
// ----------------------------------------------------------------------------
// mhm_pkg: shared types and constants of the moving harmonic mean block
// Field widths, fixed-point formats and the control/status bundles that
// run between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package mhm_pkg;

   localparam int RATE_W     = 24;               // Q16.8 reading and mean
   localparam int CFG_W      = 7;                // window length, fill count
   localparam int RECIP_W    = 40;               // Q8.32 reciprocal
   localparam int DIVIDEND_W = CFG_W + RECIP_W;  // count scaled by 2^40

   // Commands from the sequencer, at most one high in a cycle
   typedef struct packed {
      logic load;       // take the item, advance write position and fill
      logic store;      // write the reading into the ring, open the walk
      logic read;       // fetch the ring entry under the walk index
      logic div_recip;  // start the divider on 2^40 / entry
      logic accum;      // add the reciprocal, step the walk
      logic div_mean;   // start the divider on count * 2^40 / sum
      logic deliver;    // load the result register
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;   // divider quotient ready
      logic walk_last;  // current entry is the oldest one counted
      logic out_free;   // result register can take a new item
   } dp_status_type;

endpackage

[design/mhm_if.sv]
// ----------------------------------------------------------------------------
// mhm_if: channel interfaces of the moving harmonic mean block
// Valid/ready channels for readings, results and the window length write.
// ----------------------------------------------------------------------------
interface mhm_req_if;
   logic                         valid;
   logic                         ready;
   logic [mhm_pkg::RATE_W-1:0]   rate_reading;

   modport source (output valid, output rate_reading, input ready);
   modport sink   (input valid, input rate_reading, output ready);
endinterface

interface mhm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mhm_pkg::RATE_W-1:0]   mean_rate;
   logic [mhm_pkg::CFG_W-1:0]    samples_in_window;

   modport source (output valid, output mean_rate, output samples_in_window, input ready);
   modport sink   (input valid, input mean_rate, input samples_in_window, output ready);
endinterface

interface mhm_csr_if;
   logic                         valid;
   logic                         ready;
   logic [mhm_pkg::CFG_W-1:0]    window_length;

   modport source (output valid, output window_length, input ready);
   modport sink   (input valid, input window_length, output ready);
endinterface

[design/mhm_div.sv]
// ----------------------------------------------------------------------------
// mhm_div: restoring divider, one quotient bit per cycle
// Shares one subtract-and-compare between the reciprocal and mean divisions.
// ----------------------------------------------------------------------------
module mhm_div #(
   parameter int DIVIDEND_W = 47,
   parameter int DIVISOR_W  = 46
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // A zero divisor always fits, so the quotient comes out all ones
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[design/mhm_ctrl.sv]
// ----------------------------------------------------------------------------
// mhm_ctrl: sequencer of the moving harmonic mean block
// Takes one item, walks the counted ring entries through the divider,
// then divides the count by the reciprocal sum and hands the result on.
// ----------------------------------------------------------------------------
module mhm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output mhm_pkg::dp_cmd_type    cmd,
   input  mhm_pkg::dp_status_type status
);

   typedef enum logic [2:0] {
      IDLE,
      STORE,
      READ,
      RECIP,
      RWAIT,
      MEAN,
      MWAIT,
      DELIVER
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ready_in = ready_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = STORE;
               ready_in = 1'b0;
            end
         end
         STORE: begin
            cmd.store = 1'b1;
            state_in  = READ;
         end
         READ: begin
            cmd.read = 1'b1;
            state_in = RECIP;
         end
         RECIP: begin
            cmd.div_recip = 1'b1;
            state_in      = RWAIT;
         end
         RWAIT: begin
            if (status.div_done) begin
               cmd.accum = 1'b1;
               state_in  = status.walk_last ? MEAN : READ;
            end
         end
         MEAN: begin
            cmd.div_mean = 1'b1;
            state_in     = MWAIT;
         end
         MWAIT: begin
            if (status.div_done) begin
               state_in = DELIVER;
            end
         end
         DELIVER: begin
            // hold the quotient until the result register frees up
            if (status.out_free) begin
               cmd.deliver = 1'b1;
               state_in    = IDLE;
               ready_in    = 1'b1;
            end
         end
         default: begin
            state_in = IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

[design/mhm_dpath.sv]
// ----------------------------------------------------------------------------
// mhm_dpath: datapath of the moving harmonic mean block
// Reading ring, window pointers, reciprocal accumulator, shared divider and
// the result register.
// ----------------------------------------------------------------------------
module mhm_dpath #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mhm_pkg::dp_cmd_type          cmd,
   output mhm_pkg::dp_status_type       status,
   input  logic [mhm_pkg::RATE_W-1:0]   rate_reading,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [mhm_pkg::CFG_W-1:0]    csr_window_length,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [mhm_pkg::RATE_W-1:0]   mean_rate,
   output logic [mhm_pkg::CFG_W-1:0]    samples_in_window
);

   localparam int RATE_W  = mhm_pkg::RATE_W;
   localparam int FILL_W  = mhm_pkg::CFG_W;
   localparam int RECIP_W = mhm_pkg::RECIP_W;
   localparam int DVD_W   = mhm_pkg::DIVIDEND_W;
   localparam int PTR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_W   = RECIP_W + $clog2(MAX_WINDOW);

   logic [RATE_W-1:0]  ring_mem [MAX_WINDOW];
   logic [RATE_W-1:0]  rdata_ff;
   logic [RATE_W-1:0]  reading_ff;

   logic [FILL_W-1:0]  len_ff, len_in, len_cfg;
   logic [PTR_W-1:0]   wp_ff, wp_in, wp_next;
   logic [FILL_W-1:0]  fill_ff, fill_in, fill_next;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [PTR_W-1:0]   idx_ff, idx_in, idx_prev;
   logic [FILL_W-1:0]  left_ff, left_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [RATE_W-1:0]  mean_ff, mean_in;
   logic [FILL_W-1:0]  samples_ff, samples_in;

   logic               div_start;
   logic [DVD_W-1:0]   div_dividend;
   logic [SUM_W-1:0]   div_divisor;
   logic               div_done;
   logic [DVD_W-1:0]   div_quotient;
   logic [RECIP_W-1:0] recip_sat;
   logic [RATE_W-1:0]  mean_sat;

   // Clamp the written window length to 1 .. MAX_WINDOW
   always_comb begin
      if (csr_window_length == '0) begin
         len_cfg = FILL_W'(1);
      end else if (32'(csr_window_length) > 32'(MAX_WINDOW)) begin
         len_cfg = FILL_W'(MAX_WINDOW);
      end else begin
         len_cfg = csr_window_length;
      end
   end

   assign wp_next   = (32'(wp_ff) + 32'd1 == 32'(len_ff)) ? '0 : wp_ff + PTR_W'(1);
   assign fill_next = (fill_ff == len_ff) ? fill_ff : fill_ff + FILL_W'(1);
   assign idx_prev  = (idx_ff == '0) ? PTR_W'(len_ff - FILL_W'(1)) : idx_ff - PTR_W'(1);

   // Config write resets the history; old ring contents are never reached
   // again because the walk only covers entries written since.
   always_comb begin
      len_in       = len_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      if (csr_valid) begin
         len_in  = len_cfg;
         wp_in   = '0;
         fill_in = '0;
      end else if (cmd.load) begin
         wp_in   = wp_next;
         fill_in = fill_next;
      end
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= FILL_W'(1);
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Saturate the divider output to the reciprocal and mean formats
   assign recip_sat = (|div_quotient[DVD_W-1:RECIP_W]) ? '1 : div_quotient[RECIP_W-1:0];
   assign mean_sat  = (|div_quotient[DVD_W-1:RATE_W]) ? '1 : div_quotient[RATE_W-1:0];

   always_comb begin
      idx_in     = idx_ff;
      left_in    = left_ff;
      sum_in     = sum_ff;
      mean_in    = mean_ff;
      samples_in = samples_ff;
      if (cmd.store) begin
         idx_in  = wp_ff;
         left_in = fill_ff;
         sum_in  = '0;
      end else if (cmd.accum) begin
         idx_in  = idx_prev;
         left_in = left_ff - FILL_W'(1);
         sum_in  = sum_ff + SUM_W'(recip_sat);
      end
      if (cmd.deliver) begin
         mean_in    = mean_sat;
         samples_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         reading_ff <= rate_reading;
      end
      idx_ff     <= idx_in;
      left_ff    <= left_in;
      sum_ff     <= sum_in;
      mean_ff    <= mean_in;
      samples_ff <= samples_in;
   end

   // Ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         ring_mem[wp_ff] <= reading_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rdata_ff <= ring_mem[idx_ff];
      end
   end

   assign div_start    = cmd.div_recip | cmd.div_mean;
   assign div_dividend = cmd.div_mean ? {fill_ff, {RECIP_W{1'b0}}}
                                      : (DVD_W'(1) << RECIP_W);
   assign div_divisor  = cmd.div_mean ? sum_ff : SUM_W'(rdata_ff);

   mhm_div #(
      .DIVIDEND_W (DVD_W),
      .DIVISOR_W  (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign status.div_done  = div_done;
   assign status.walk_last = (left_ff == FILL_W'(1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign mean_rate         = mean_ff;
   assign samples_in_window = samples_ff;

endmodule

[design/moving_harmonic_mean_rate.sv]
// One item is worked at a time: the next item is taken only after the previous
// result has been loaded into the result register.
// Each counted entry costs one ring read, a 47-step divider pass and an accumulate.
// Reset (synchronous, active high): window length 1, empty history, no result held.
// A window length write is always accepted (csr_ready is tied high) and also empties the history.
// ----------------------------------------------------------------------------
// moving_harmonic_mean_rate: windowed harmonic mean of rate readings
// Stores each Q16.8 reading in a ring and returns the count divided by the
// sum of Q8.32 reciprocals over the most recent readings, saturated Q16.8.
// ----------------------------------------------------------------------------
module moving_harmonic_mean_rate #(
   parameter int MAX_WINDOW = 64
) (
   input  logic       clock,
   input  logic       reset,
   mhm_req_if.sink    req_chan,
   mhm_rsp_if.source  rsp_chan,
   mhm_csr_if.sink    csr_chan
);

   // Sequencer and datapath talk through these two bundles only
   mhm_pkg::dp_cmd_type    cmd;
   mhm_pkg::dp_status_type status;

   // Sequencer: accepts an item only when idle, then steps the walk.
   // The result register sits in the datapath, so a new item is taken
   // while the previous result still waits on rsp_chan.
   mhm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath: ring memory of MAX_WINDOW readings, write position and fill
   // count, reciprocal sum and the shared bit-serial divider.
   mhm_dpath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .rate_reading      (req_chan.rate_reading),
      .csr_valid         (csr_chan.valid),
      .csr_ready         (csr_chan.ready),
      .csr_window_length (csr_chan.window_length),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .mean_rate         (rsp_chan.mean_rate),
      .samples_in_window (rsp_chan.samples_in_window)
   );

endmodule

[design/mhm_check.sv]
// ----------------------------------------------------------------------------
// mhm_check: port-level checks of the moving harmonic mean block
// Tracks items in flight and the expected fill count from the ports alone.
// ----------------------------------------------------------------------------
module mhm_check #(
   parameter int MAX_WINDOW = 64
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [mhm_pkg::RATE_W-1:0]   mean_rate,
   input logic [mhm_pkg::CFG_W-1:0]    samples_in_window,
   input logic                         csr_valid,
   input logic                         csr_ready,
   input logic [mhm_pkg::CFG_W-1:0]    csr_window_length
);

   localparam int FILL_W = mhm_pkg::CFG_W;

   logic [1:0]        pending_ff, pending_in;
   logic [FILL_W-1:0] len_ff, len_in, len_cfg;
   logic [FILL_W-1:0] fill_ff, fill_in, fill_next;
   logic              req_acc, rsp_acc;

   assign req_acc   = req_valid && req_ready;
   assign rsp_acc   = rsp_valid && rsp_ready;
   assign fill_next = (fill_ff == len_ff) ? fill_ff : fill_ff + FILL_W'(1);

   always_comb begin
      if (csr_window_length == '0) begin
         len_cfg = FILL_W'(1);
      end else if (32'(csr_window_length) > 32'(MAX_WINDOW)) begin
         len_cfg = FILL_W'(MAX_WINDOW);
      end else begin
         len_cfg = csr_window_length;
      end
   end

   always_comb begin
      pending_in = pending_ff + 2'(req_acc) - 2'(rsp_acc);
      len_in     = len_ff;
      fill_in    = fill_ff;
      if (csr_valid && csr_ready) begin
         len_in  = len_cfg;
         fill_in = '0;
      end else if (rsp_acc) begin
         fill_in = fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         len_ff     <= FILL_W'(1);
         fill_ff    <= '0;
      end else begin
         pending_ff <= pending_in;
         len_ff     <= len_in;
         fill_ff    <= fill_in;
      end
   end

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(mean_rate)
                                  && $stable(samples_in_window))
      else $error("result dropped or changed while stalled");

   // No result without an item behind it
   a_rsp_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result shown with no item outstanding");

   // One item in work plus one waiting result at most
   a_no_third: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 |-> !req_ready)
      else $error("item accepted with two already outstanding");

   // Fill count grows by one per result up to the window length
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> samples_in_window == fill_next)
      else $error("samples_in_window out of step with the window");

endmodule

bind moving_harmonic_mean_rate mhm_check #(
   .MAX_WINDOW (MAX_WINDOW)
) u_mhm_check (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .mean_rate         (rsp_chan.mean_rate),
   .samples_in_window (rsp_chan.samples_in_window),
   .csr_valid         (csr_chan.valid),
   .csr_ready         (csr_chan.ready),
   .csr_window_length (csr_chan.window_length)
);

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for moving_harmonic_mean_rate
// Drives rate readings and window length writes through the valid/ready
// channels, predicts each untyped mean and window count from a behavioural
// copy of the block, and checks each result in order of arrival.
// ----------------------------------------------------------------------------
module tb;

   localparam int RATE_W  = mhm_pkg::RATE_W;
   localparam int CFG_W   = mhm_pkg::CFG_W;
   localparam int RECIP_W = mhm_pkg::RECIP_W;

   localparam int MAX_WIN      = 64;
   localparam int RANDOM_ITEMS = 120;
   localparam int TAIL_CYCLES  = 3300;       // longest latency, 64-entry window
   // Worst case: every item at a 64-entry window with the longest stalls,
   // taken several times over.
   localparam int CYCLE_LIMIT  = 2_500_000;

   localparam logic [RATE_W-1:0] MEAN_SAT = '1;

   typedef enum logic {ROW_READING, ROW_WINDOW} row_kind_type;

   // One stimulus row: a reading (with its result typed in where it is
   // obvious) or a window length write.
   typedef struct packed {
      row_kind_type      kind;
      logic [RATE_W-1:0] value;
      logic              typed;
      logic [RATE_W-1:0] mean;
      logic [CFG_W-1:0]  count;
   } stim_row_type;

   typedef struct packed {
      logic [RATE_W-1:0] mean;
      logic [CFG_W-1:0]  count;
   } mean_result_type;

   localparam int DIRECTED_ROWS = 27;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // window of one straight after reset
      '{ROW_READING, 24'h000000, 1'b1, 24'h000001, 7'd1},  // zero reading
      '{ROW_READING, 24'h000001, 1'b1, 24'h000001, 7'd1},  // reciprocal saturates
      '{ROW_READING, 24'h000002, 1'b1, 24'h000002, 7'd1},
      '{ROW_READING, 24'h000100, 1'b1, 24'h000100, 7'd1},
      '{ROW_READING, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 7'd1},  // mean saturates
      '{ROW_READING, 24'h800000, 1'b1, 24'h800000, 7'd1},
      // window length zero behaves as one
      '{ROW_WINDOW,  24'd0,      1'b0, 24'h000000, 7'd0},
      '{ROW_READING, 24'h000200, 1'b1, 24'h000200, 7'd1},
      // short window, fill and wrap
      '{ROW_WINDOW,  24'd3,      1'b0, 24'h000000, 7'd0},
      '{ROW_READING, 24'h000100, 1'b1, 24'h000100, 7'd1},
      '{ROW_READING, 24'h000100, 1'b1, 24'h000100, 7'd2},
      '{ROW_READING, 24'h000000, 1'b0, 24'h000000, 7'd0},
      '{ROW_READING, 24'h000400, 1'b0, 24'h000000, 7'd0},
      '{ROW_READING, 24'h000001, 1'b0, 24'h000000, 7'd0},
      // longest encodable length, clamped to the ring size
      '{ROW_WINDOW,  24'd127,    1'b0, 24'h000000, 7'd0},
      '{ROW_READING, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 7'd1},
      '{ROW_READING, 24'hFFFFFF, 1'b1, 24'hFFFFFF, 7'd2},
      '{ROW_READING, 24'h000000, 1'b0, 24'h000000, 7'd0},
      // full ring
      '{ROW_WINDOW,  24'd64,     1'b0, 24'h000000, 7'd0},
      '{ROW_READING, 24'h000100, 1'b1, 24'h000100, 7'd1},
      '{ROW_READING, 24'h000100, 1'b1, 24'h000100, 7'd2},
      '{ROW_WINDOW,  24'd2,      1'b0, 24'h000000, 7'd0},
      '{ROW_READING, 24'h555555, 1'b0, 24'h000000, 7'd0},
      '{ROW_READING, 24'hAAAAAA, 1'b0, 24'h000000, 7'd0},
      '{ROW_READING, 24'h123456, 1'b0, 24'h000000, 7'd0},
      '{ROW_WINDOW,  24'd1,      1'b0, 24'h000000, 7'd0},
      '{ROW_READING, 24'h000100, 1'b1, 24'h000100, 7'd1}
   };

   logic clock = 1'b0;
   logic reset;

   mhm_req_if req_chan ();
   mhm_rsp_if rsp_chan ();
   mhm_csr_if csr_chan ();

   moving_harmonic_mean_rate #(
      .MAX_WINDOW (MAX_WIN)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Behavioural copy of the window: configured length, reading history,
   // write position and fill count.
   logic [CFG_W-1:0]  window_cfg;
   logic [RATE_W-1:0] reading_hist [MAX_WIN];
   int unsigned       hist_pos;
   int unsigned       hist_fill;

   mean_result_type pending_means [$];   // predicted results, oldest first
   int              error_count = 0;
   int              cycle_count = 0;
   bit              idling_on;

   function automatic void clear_history();
      foreach (reading_hist[i]) reading_hist[i] = '0;
      hist_pos  = 0;
      hist_fill = 0;
   endfunction

   function automatic int unsigned window_span(input logic [CFG_W-1:0] wl);
      int unsigned span;
      span = wl;
      if (span < 1) span = 1;
      if (span > MAX_WIN) span = MAX_WIN;
      return span;
   endfunction

   // Q8.32 reciprocal of a Q16.8 reading; zero and one both give the largest
   // representable value.
   function automatic logic [RECIP_W-1:0] reciprocal_q832(input logic [RATE_W-1:0] r);
      logic [RECIP_W:0] q;
      if (r == '0) return '1;
      q = (41'd1 << 40) / {17'd0, r};
      if (q[RECIP_W]) return '1;
      return q[RECIP_W-1:0];
   endfunction

   // Store one reading and work out the harmonic mean over the window.
   function automatic void harmonic_mean_step(input logic [RATE_W-1:0] r,
                                              output mean_result_type res);
      int unsigned span;
      int unsigned idx;
      logic [47:0] total;
      logic [47:0] quot;
      span = window_span(window_cfg);
      if (hist_pos >= span) hist_pos = 0;
      hist_pos = (hist_pos + 1) % span;
      if (hist_fill > span) hist_fill = span;
      if (hist_fill < span) hist_fill++;
      reading_hist[hist_pos] = r;
      total = '0;
      for (int unsigned i = 0; i < hist_fill; i++) begin
         idx   = (hist_pos + span - i) % span;
         total = total + 48'(reciprocal_q832(reading_hist[idx]));
      end
      if (total == '0) begin
         quot = '1;
      end else begin
         quot = (48'(hist_fill) << 40) / total;
      end
      res.mean  = (quot > 48'(MEAN_SAT)) ? MEAN_SAT : quot[RATE_W-1:0];
      res.count = CFG_W'(hist_fill);
   endfunction

   // Mostly plausible frame rates, with zero, one, full scale and raw
   // 24-bit patterns mixed in so every bit toggles.
   function automatic logic [RATE_W-1:0] draw_reading();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 24'd1;
         2:       return '1;
         3:       return RATE_W'($urandom_range(2, 255));
         4, 5, 6: return RATE_W'($urandom_range(7680, 61440));   // 30 to 240 fps
         7:       return RATE_W'($urandom_range(256, 65535));
         default: return RATE_W'($urandom());
      endcase
   endfunction

   // Offer one reading from a falling edge, hold it until taken, then record
   // its expected result. Return at the next falling edge with valid still high.
   task automatic send_reading(input logic [RATE_W-1:0] r, input bit typed,
                               input mean_result_type typed_res);
      mean_result_type predicted;
      req_chan.valid        <= 1'b1;
      req_chan.rate_reading <= r;
      do @(posedge clock); while (!req_chan.ready);
      harmonic_mean_step(r, predicted);
      pending_means.push_back(typed ? typed_res : predicted);
      @(negedge clock);
   endtask

   // Drop valid for a random burst now and then.
   task automatic take_gap();
      if (idling_on && $urandom_range(0, 2) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   // Write the window length once the block has drained; this also empties
   // the history, so mirror that in the predictor.
   task automatic write_window(input logic [CFG_W-1:0] wl);
      req_chan.valid <= 1'b0;
      while (pending_means.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_chan.valid         <= 1'b1;
      csr_chan.window_length <= wl;
      do @(posedge clock); while (!csr_chan.ready);
      window_cfg = wl;
      clear_history();
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Result side: hold ready low for random bursts while idling is on.
   initial begin
      int stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 17);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Check each delivered item against the oldest prediction.
   always @(posedge clock) begin : check_results
      mean_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_means.size() == 0) begin
            $display("%0t: unexpected result, expected none, got mean %h count %0d",
                     $time, rsp_chan.mean_rate, rsp_chan.samples_in_window);
            error_count++;
         end else begin
            want = pending_means.pop_front();
            if (rsp_chan.mean_rate !== want.mean) begin
               $display("%0t: mean_rate expected %h, got %h",
                        $time, want.mean, rsp_chan.mean_rate);
               error_count++;
            end
            if (rsp_chan.samples_in_window !== want.count) begin
               $display("%0t: samples_in_window expected %0d, got %0d",
                        $time, want.count, rsp_chan.samples_in_window);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run if it hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: errors");
      $finish;
   end

   initial begin
      logic [CFG_W-1:0] wl;
      int unsigned      span;
      int               n;
      int               items_left;
      bit               first_phase;
      bit               phase_idle;
      mean_result_type  typed_res;

      // Hold every input at a known value with reset high, then release reset.
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.rate_reading  = '0;
      csr_chan.valid         = 1'b0;
      csr_chan.window_length = '0;
      idling_on              = 1'b1;
      window_cfg             = 7'd1;
      clear_history();
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows: typed results where obvious, predictor elsewhere.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WINDOW) begin
            write_window(directed_rows[i].value[CFG_W-1:0]);
         end else begin
            typed_res.mean  = directed_rows[i].mean;
            typed_res.count = directed_rows[i].count;
            send_reading(directed_rows[i].value, directed_rows[i].typed, typed_res);
            take_gap();
         end
      end

      // Random phases. Open with a full-ring window long enough to saturate the
      // fill count and wrap; then mostly short windows to keep the run brief.
      items_left  = RANDOM_ITEMS;
      first_phase = 1'b1;
      typed_res   = '0;
      while (items_left > 0) begin
         if (first_phase) begin
            wl = CFG_W'($urandom_range(64, 127));
         end else begin
            case ($urandom_range(0, 5))
               0:       wl = '0;
               5:       wl = CFG_W'($urandom_range(11, 40));
               default: wl = CFG_W'($urandom_range(1, 10));
            endcase
         end
         span = window_span(wl);
         n    = first_phase ? span + 6 : span + $urandom_range(1, 8);
         if (n > items_left) n = items_left;
         first_phase = 1'b0;
         phase_idle  = ($urandom_range(0, 3) != 0);
         idling_on   = phase_idle && items_left > 20;
         write_window(wl);
         repeat (n) begin
            // Run the closing stretch without any idling.
            idling_on = phase_idle && items_left > 20;
            send_reading(draw_reading(), 1'b0, typed_res);
            take_gap();
            items_left--;
         end
      end

      // Drain, then watch a little longer for stray results.
      idling_on = 1'b0;
      req_chan.valid <= 1'b0;
      while (pending_means.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
